// File: rtl/core/hsvc_pkg.sv
`default_nettype none

package hsvc_pkg;

   localparam int unsigned HueWidth   = 16;
   localparam int unsigned ChanWidth  = 8;
   localparam int unsigned TermWidth  = 24;

   // Full scale of an 8-bit channel, and that scale times one hue sector.
   localparam logic [ChanWidth-1:0] FullScale = 8'd255;
   localparam logic [TermWidth-1:0] LevelDen  = 24'd16711680;

   // Six sectors of the color wheel.
   localparam logic [2:0] SecRedYellow     = 3'd0;
   localparam logic [2:0] SecYellowGreen   = 3'd1;
   localparam logic [2:0] SecGreenCyan     = 3'd2;
   localparam logic [2:0] SecCyanBlue      = 3'd3;
   localparam logic [2:0] SecBlueMagenta   = 3'd4;
   localparam logic [2:0] SecMagentaRed    = 3'd5;

   typedef struct packed {
      logic [2:0]           sector;
      logic [HueWidth-1:0]  frac;
      logic [ChanWidth-1:0] sat;
      logic [ChanWidth-1:0] val;
      logic [15:0]          pnum;
   } hsvc_s1_type;

   typedef struct packed {
      logic [2:0]           sector;
      logic [ChanWidth-1:0] val;
      logic [ChanWidth-1:0] plev;
      logic [TermWidth-1:0] qterm;
      logic [TermWidth-1:0] tterm;
   } hsvc_s2_type;

   typedef struct packed {
      logic [2:0]           sector;
      logic [ChanWidth-1:0] val;
      logic [ChanWidth-1:0] plev;
      logic [15:0]          qnum;
      logic [15:0]          tnum;
   } hsvc_s3_type;

   // Truncating division by 255 for x up to 255*255: the estimate x*257/65536
   // is exact or one short, and a single remainder check fixes it.
   function automatic logic [ChanWidth-1:0] div255(input logic [15:0] x);
      logic [24:0] prod;
      logic [8:0]  est;
      logic [16:0] back;
      logic [16:0] rem;
      prod = {9'd0, x} + {1'b0, x, 8'd0};
      est  = prod[24:16];
      back = {est, 8'd0} - {8'd0, est};
      rem  = {1'b0, x} - back;
      if (rem >= 17'd255) begin
         div255 = est[7:0] + 8'd1;
      end else begin
         div255 = est[7:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/hsvc_sector.sv
`default_nettype none

module hsvc_sector
   import hsvc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [HueWidth-1:0]  in_hue,
   input  wire logic [ChanWidth-1:0] in_sat,
   input  wire logic [ChanWidth-1:0] in_val,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output hsvc_s1_type               out_data
);

   logic        valid_ff;
   hsvc_s1_type data_ff;
   hsvc_s1_type data_in;
   logic [18:0] h6;

   // Six times the hue: the top bits are the sector, the rest the position.
   always_comb begin
      h6              = ({3'd0, in_hue} << 2) + ({3'd0, in_hue} << 1);
      data_in.sector  = h6[18:16];
      data_in.frac    = h6[15:0];
      data_in.sat     = in_sat;
      data_in.val     = in_val;
      data_in.pnum    = 16'(in_val) * 16'(FullScale - in_sat);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hsvc_level.sv
`default_nettype none

module hsvc_level
   import hsvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire hsvc_s1_type in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output hsvc_s2_type      out_data
);

   logic        valid_ff;
   hsvc_s2_type data_ff;
   hsvc_s2_type data_in;
   logic [23:0] fs;
   logic [16:0] fc;
   logic [24:0] fcs;
   logic [24:0] tdiff;

   // The subtracted products never exceed the full-scale denominator.
   always_comb begin
      fs              = 24'(in_data.frac) * 24'(in_data.sat);
      fc              = 17'h10000 - {1'b0, in_data.frac};
      fcs             = 25'(fc) * 25'(in_data.sat);
      tdiff           = {1'b0, LevelDen} - fcs;
      data_in.sector  = in_data.sector;
      data_in.val     = in_data.val;
      data_in.plev    = div255(in_data.pnum);
      data_in.qterm   = LevelDen - fs;
      data_in.tterm   = tdiff[23:0];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hsvc_scale.sv
`default_nettype none

module hsvc_scale
   import hsvc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire hsvc_s2_type in_data,
   output logic             out_valid,
   input  wire logic        out_ready,
   output hsvc_s3_type      out_data
);

   logic        valid_ff;
   hsvc_s3_type data_ff;
   hsvc_s3_type data_in;
   logic [31:0] qprod;
   logic [31:0] tprod;

   // Dropping the low 16 bits divides by 65536; the 255 part follows later.
   always_comb begin
      qprod           = 32'(in_data.val) * 32'(in_data.qterm);
      tprod           = 32'(in_data.val) * 32'(in_data.tterm);
      data_in.sector  = in_data.sector;
      data_in.val     = in_data.val;
      data_in.plev    = in_data.plev;
      data_in.qnum    = qprod[31:16];
      data_in.tnum    = tprod[31:16];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hsvc_select.sv
`default_nettype none

module hsvc_select
   import hsvc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire hsvc_s3_type          in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [ChanWidth-1:0]      out_red,
   output logic [ChanWidth-1:0]      out_green,
   output logic [ChanWidth-1:0]      out_blue
);

   logic                 valid_ff;
   logic [ChanWidth-1:0] red_ff;
   logic [ChanWidth-1:0] green_ff;
   logic [ChanWidth-1:0] blue_ff;
   logic [ChanWidth-1:0] red_in;
   logic [ChanWidth-1:0] green_in;
   logic [ChanWidth-1:0] blue_in;
   logic [ChanWidth-1:0] qlev;
   logic [ChanWidth-1:0] tlev;

   always_comb begin
      qlev = div255(in_data.qnum);
      tlev = div255(in_data.tnum);
      case (in_data.sector)
         SecRedYellow: begin
            red_in = in_data.val; green_in = tlev; blue_in = in_data.plev;
         end
         SecYellowGreen: begin
            red_in = qlev; green_in = in_data.val; blue_in = in_data.plev;
         end
         SecGreenCyan: begin
            red_in = in_data.plev; green_in = in_data.val; blue_in = tlev;
         end
         SecCyanBlue: begin
            red_in = in_data.plev; green_in = qlev; blue_in = in_data.val;
         end
         SecBlueMagenta: begin
            red_in = tlev; green_in = in_data.plev; blue_in = in_data.val;
         end
         default: begin
            red_in = in_data.val; green_in = in_data.plev; blue_in = qlev;
         end
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hsv_to_rgb_converter_top.sv
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_hue, req_saturation, req_brightness
// rsp       out        rsp_valid/rsp_stall   rsp_red, rsp_green, rsp_blue
//
// Each item passes four register stages, and while rsp_stall is low one
// item can be accepted every cycle.
// The stages hold the two product steps (hue sector and levels, then value
// scaling) and the final divide-by-255 and channel select.
// Reset clears only the stage valid bits; the pipeline is then empty.
// A stall on the result side backs up stage by stage: empty stages still
// take items, so req_stall rises only once every stage is holding an item.

module hsv_to_rgb_converter_top
   import hsvc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [HueWidth-1:0]  req_hue,
   input  wire logic [ChanWidth-1:0] req_saturation,
   input  wire logic [ChanWidth-1:0] req_brightness,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ChanWidth-1:0]      rsp_red,
   output logic [ChanWidth-1:0]      rsp_green,
   output logic [ChanWidth-1:0]      rsp_blue
);

   logic        s1_ready;
   logic        s1_valid;
   hsvc_s1_type s1_data;
   logic        s2_ready;
   logic        s2_valid;
   hsvc_s2_type s2_data;
   logic        s3_ready;
   logic        s3_valid;
   hsvc_s3_type s3_data;
   logic        s4_ready;

   // Stage one splits six times the hue into sector and position and forms
   // the numerator of the lowest level p.
   hsvc_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (s1_ready),
      .in_hue    (req_hue),
      .in_sat    (req_saturation),
      .in_val    (req_brightness),
      .out_valid (s1_valid),
      .out_ready (s2_ready),
      .out_data  (s1_data)
   );

   // Stage two finishes p and builds the falling and rising terms behind
   // q and t.
   hsvc_level u_level (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s2_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s3_ready),
      .out_data  (s2_data)
   );

   // Stage three scales both terms by the value.
   hsvc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s3_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s4_ready),
      .out_data  (s3_data)
   );

   // Stage four divides q and t down to channel range and routes the levels
   // to red, green and blue by sector. Zero saturation needs no special path:
   // p, q and t all equal the value then.
   hsvc_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s4_ready),
      .in_data   (s3_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

   assign req_stall = !s1_ready;

endmodule

`default_nettype wire
